[src/cplm_pkg.sv]
package cplm_pkg;

  localparam int MAX_ENTRIES_DEF = 16;

  localparam int ADDR_W  = 128;
  localparam int IDX_W   = 4;
  localparam int PLEN_W  = 8;
  localparam int CNT_W   = 5;
  localparam int CMP_W   = 9;

  localparam logic [CNT_W-1:0]  ENTRY_COUNT_RST = 5'd16;
  localparam logic [PLEN_W-1:0] V4_MAX_PREFIX   = 8'd32;
  localparam logic [PLEN_W-1:0] V6_MAX_PREFIX   = 8'd128;

  typedef enum logic {
    REQ_WRITE  = 1'b0,
    REQ_LOOKUP = 1'b1
  } req_t;

  typedef struct packed {
    req_t              req;
    logic              v6;
    logic [IDX_W-1:0]  idx;
    logic              ok;
    logic [ADDR_W-1:0] addr;
    logic [PLEN_W-1:0] plen;
    logic              hit;
  } item_t;

  function automatic logic [ADDR_W-1:0] prefix_mask(input logic [PLEN_W-1:0] plen);
    logic [ADDR_W-1:0] m;
    for (int j = 0; j < ADDR_W; j++) begin
      m[ADDR_W-1-j] = (PLEN_W'(j) < plen);
    end
    return m;
  endfunction

endpackage

[src/cplm_cell.sv]
module cplm_cell #(
  parameter int CELL_IDX = 0
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    adv,
  input  logic [cplm_pkg::CNT_W-1:0] cnt,
  input  logic                    in_vld,
  input  cplm_pkg::item_t         in_item,
  output logic                    out_vld,
  output cplm_pkg::item_t         out_item
);
  import cplm_pkg::*;

  logic              vld_r;
  item_t             item_r;
  item_t             item_nxt;
  logic              ent_vld_r;
  logic              fam_r;
  logic [ADDR_W-1:0] addr_r;
  logic [ADDR_W-1:0] mask_r;
  logic              active;
  logic              wr_hit;
  logic              look_hit;

  assign active = (CMP_W'(CELL_IDX) < {{(CMP_W-CNT_W){1'b0}}, cnt});

  assign wr_hit = in_vld && (in_item.req == REQ_WRITE) && in_item.ok &&
                  (CMP_W'(CELL_IDX) == {{(CMP_W-IDX_W){1'b0}}, in_item.idx});

  assign look_hit = (in_item.req == REQ_LOOKUP) && active && ent_vld_r &&
                    (fam_r == in_item.v6) &&
                    (((in_item.addr ^ addr_r) & mask_r) == '0);

  always_comb begin
    item_nxt     = in_item;
    item_nxt.hit = in_item.hit | look_hit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= 1'b0;
      ent_vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= in_vld;
      if (wr_hit) begin
        ent_vld_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      item_r <= item_nxt;
      if (wr_hit) begin
        fam_r  <= in_item.v6;
        addr_r <= in_item.addr;
        mask_r <= prefix_mask(in_item.plen);
      end
    end
  end

  assign out_vld  = vld_r;
  assign out_item = item_r;

endmodule

[src/cidr_prefix_list_matcher.sv]
// Each transaction is registered by every cell of the chain in turn, from cell 0 to the last.
// Throughput: one transaction per cycle; the whole chain holds while a result waits
// with out_tready low.
// Each cell owns one table entry; a write is stored as it passes its slot,
// a lookup collects hits from every active cell (index below entry_count) it passes.
// Reset: synchronous, active low; clears all entry valid bits and sets entry_count to 16.
module cidr_prefix_list_matcher #(
  parameter int MAX_ENTRIES = cplm_pkg::MAX_ENTRIES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // entry_index[3:0], addr_hi[67:4], addr_lo[131:68], prefix_len[139:132], zero pad
  input  logic [143:0]               in_tdata,
  // req_type[0], is_ipv6[1]
  input  logic [1:0]                 in_tuser,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // matched[0], write_ok[1], zero pad
  output logic [7:0]                 out_tdata,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [cplm_pkg::CNT_W-1:0] cfg_data
);
  import cplm_pkg::*;

  logic [CNT_W-1:0] cnt_r;
  logic             adv;
  item_t            in_item;
  logic [PLEN_W-1:0] maxp;
  logic             idx_ok;
  logic             vld_w  [MAX_ENTRIES+1];
  item_t            item_w [MAX_ENTRIES+1];
  item_t            last;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= ENTRY_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      cnt_r <= cfg_data;
    end
  end

  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  assign maxp   = in_tuser[1] ? V6_MAX_PREFIX : V4_MAX_PREFIX;
  assign idx_ok = ({{(CMP_W-IDX_W){1'b0}}, in_tdata[3:0]} < CMP_W'(MAX_ENTRIES)) &&
                  ({{(CNT_W-IDX_W){1'b0}}, in_tdata[3:0]} < cnt_r);

  always_comb begin
    in_item.req  = req_t'(in_tuser[0]);
    in_item.v6   = in_tuser[1];
    in_item.idx  = in_tdata[3:0];
    in_item.addr = {in_tdata[67:4], in_tdata[131:68]};
    in_item.plen = in_tdata[139:132];
    in_item.ok   = idx_ok && (in_tdata[139:132] <= maxp);
    in_item.hit  = 1'b0;
  end

  assign vld_w[0]  = in_tvalid;
  assign item_w[0] = in_item;

  for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_cell
    cplm_cell #(
      .CELL_IDX (k)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .cnt      (cnt_r),
      .in_vld   (vld_w[k]),
      .in_item  (item_w[k]),
      .out_vld  (vld_w[k+1]),
      .out_item (item_w[k+1])
    );
  end

  assign last       = item_w[MAX_ENTRIES];
  assign out_tvalid = vld_w[MAX_ENTRIES];
  assign out_tdata  = {6'b0, (last.req == REQ_WRITE) && last.ok, last.hit};

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && out_tdata[1]))
    else $error("matched and write_ok both set");

  a_ok_only_on_write: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[1]) |-> (last.req == REQ_WRITE))
    else $error("write_ok on a lookup result");

  a_hit_only_on_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[0]) |-> (last.req == REQ_LOOKUP))
    else $error("matched on a write result");

  a_empty_after_reset: assert property (@(posedge clk)
    (rst_n && $past(!rst_n)) |-> !out_tvalid)
    else $error("result valid right after reset");

endmodule
